>>> hw/rtl/pit_pkg.sv
package pit_pkg;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [15:0]       elapsed_ms;
    logic [1:0]        tilt;
    logic signed [7:0] rotary;
    logic              short_press;
    logic [39:0]       timestamp_us;
  } pit_in_t;

  typedef struct packed {
    logic [12:0] secs_remain;
    logic        work_phase;
    logic        running;
    logic [6:0]  work_min;
    logic [6:0]  break_min;
    logic        adjusting;
    logic [6:0]  adjust_value;
    logic [1:0]  button_index;
    logic        go_back;
    logic        phase_switched;
    logic [8:0]  dial_angle;
  } pit_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MS_MUL,
    ST_MS_REM,
    ST_TICK,
    ST_USER,
    ST_ANG_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic ms_mul;
    logic ms_rem;
    logic tick;
    logic user;
    logic ang_load;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic tick_zero;
    logic div_last;
  } sts_t;

  localparam logic [1:0] REQ_TIME = 2'd0;
  localparam logic [1:0] REQ_USER = 2'd1;
  localparam logic [1:0] REQ_PAGE = 2'd2;

  localparam logic [1:0] TILT_FRONT = 2'd1;
  localparam logic [1:0] TILT_BACK  = 2'd2;

  localparam logic [1:0] BTN_START = 2'd0;
  localparam logic [1:0] BTN_WORK  = 2'd1;
  localparam logic [1:0] BTN_BREAK = 2'd2;
  localparam logic [1:0] BTN_BACK  = 2'd3;

  localparam logic [19:0] COOLDOWN_RESET = 20'd300000;
  localparam logic [16:0] MS_PER_SEC     = 17'd1000;
  // floor(x * MS_RECIP >> MS_RECIP_SHIFT) == x / 1000 for all 17-bit sums used here
  localparam logic [16:0] MS_RECIP       = 17'd67109;
  localparam int          MS_RECIP_SHIFT = 26;
  localparam logic [8:0]  ANGLE_FULL     = 9'd360;
  localparam logic [6:0]  MIN_LEN        = 7'd1;
  localparam logic [6:0]  MAX_LEN        = 7'd99;
  localparam int          ANG_QW         = 9;

endpackage

>>> hw/rtl/pit_ctrl.sv
module pit_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_req,
  output logic          out_valid,
  input  logic          out_ready,
  input  pit_pkg::sts_t sts,
  output pit_pkg::cmd_t cmd
);

  pit_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pit_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      pit_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = (in_req == pit_pkg::REQ_TIME) ? pit_pkg::ST_MS_MUL : pit_pkg::ST_USER;
        end
      end
      pit_pkg::ST_MS_MUL: begin
        cmd.ms_mul = 1'b1;
        state_nxt  = pit_pkg::ST_MS_REM;
      end
      pit_pkg::ST_MS_REM: begin
        cmd.ms_rem = 1'b1;
        state_nxt  = pit_pkg::ST_TICK;
      end
      pit_pkg::ST_TICK: begin
        if (sts.tick_zero) state_nxt = pit_pkg::ST_ANG_LOAD;
        else cmd.tick = 1'b1;
      end
      pit_pkg::ST_USER: begin
        cmd.user  = 1'b1;
        state_nxt = pit_pkg::ST_ANG_LOAD;
      end
      pit_pkg::ST_ANG_LOAD: begin
        cmd.ang_load = 1'b1;
        state_nxt    = pit_pkg::ST_DIV;
      end
      pit_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = pit_pkg::ST_DONE;
      end
      pit_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = pit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pit_pkg::ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/pit_dp.sv
module pit_dp #(
  parameter int DEFAULT_WORK_MIN     = 25,
  parameter int DEFAULT_BREAK_MIN    = 5,
  parameter int MAX_SECONDS_PER_ITEM = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [19:0]      cfg_wdata,
  input  pit_pkg::pit_in_t in_item,
  input  pit_pkg::cmd_t    cmd,
  output pit_pkg::sts_t    sts,
  output pit_pkg::pit_out_t out_item
);

  localparam int TW  = $clog2(MAX_SECONDS_PER_ITEM + 1);
  localparam int DCW = $clog2(pit_pkg::ANG_QW);
  localparam int DSW = 13 + pit_pkg::ANG_QW - 1;

  function automatic logic [12:0] min_to_sec(input logic [6:0] m);
    return ({6'b0, m} << 6) - ({6'b0, m} << 2);
  endfunction

  // state with reset
  logic [19:0]    cooldown_r,  cooldown_nxt;
  logic [6:0]     work_len_r,  work_len_nxt;
  logic [6:0]     break_len_r, break_len_nxt;
  logic           in_work_r,   in_work_nxt;
  logic [12:0]    secs_r,      secs_nxt;
  logic           running_r,   running_nxt;
  logic [9:0]     ms_acc_r,    ms_acc_nxt;
  logic [1:0]     pos_r,       pos_nxt;
  logic           adj_r,       adj_nxt;
  logic           adj_tgt_r,   adj_tgt_nxt;
  logic [6:0]     adj_min_r,   adj_min_nxt;
  logic [39:0]    last_mv_r,   last_mv_nxt;
  logic [TW-1:0]  tick_cnt_r,  tick_cnt_nxt;
  logic [DCW-1:0] dcnt_r,      dcnt_nxt;

  // working registers
  pit_pkg::pit_in_t  item_r,  item_nxt;
  pit_pkg::pit_out_t out_r,   out_nxt;
  logic [16:0]       total_r, total_nxt;
  logic [6:0]        q_r,     q_nxt;
  logic [21:0]       rem_r,   rem_nxt;
  logic [DSW-1:0]    dsh_r,   dsh_nxt;
  logic [pit_pkg::ANG_QW-1:0] quo_r, quo_nxt;
  logic              ang_ok_r, ang_ok_nxt;
  logic              back_r,  back_nxt;
  logic              sw_r,    sw_nxt;

  logic [33:0]       ms_prod;
  logic [16:0]       ms_left;
  logic signed [8:0] adj_sum;
  logic [6:0]        adj_clamp;
  logic [39:0]       mv_diff;
  logic              mv_ok;
  logic              mv_req;
  logic              mv_fwd;
  logic [12:0]       cur_total;
  logic [21:0]       dsh_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooldown_r  <= pit_pkg::COOLDOWN_RESET;
      work_len_r  <= 7'(DEFAULT_WORK_MIN);
      break_len_r <= 7'(DEFAULT_BREAK_MIN);
      in_work_r   <= 1'b1;
      secs_r      <= 13'(DEFAULT_WORK_MIN * 60);
      running_r   <= 1'b0;
      ms_acc_r    <= '0;
      pos_r       <= pit_pkg::BTN_START;
      adj_r       <= 1'b0;
      adj_tgt_r   <= 1'b0;
      adj_min_r   <= pit_pkg::MIN_LEN;
      last_mv_r   <= '0;
      tick_cnt_r  <= '0;
      dcnt_r      <= '0;
    end else begin
      cooldown_r  <= cooldown_nxt;
      work_len_r  <= work_len_nxt;
      break_len_r <= break_len_nxt;
      in_work_r   <= in_work_nxt;
      secs_r      <= secs_nxt;
      running_r   <= running_nxt;
      ms_acc_r    <= ms_acc_nxt;
      pos_r       <= pos_nxt;
      adj_r       <= adj_nxt;
      adj_tgt_r   <= adj_tgt_nxt;
      adj_min_r   <= adj_min_nxt;
      last_mv_r   <= last_mv_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      dcnt_r      <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    out_r    <= out_nxt;
    total_r  <= total_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    quo_r    <= quo_nxt;
    ang_ok_r <= ang_ok_nxt;
    back_r   <= back_nxt;
    sw_r     <= sw_nxt;
  end

  assign cur_total = min_to_sec(in_work_r ? work_len_r : break_len_r);
  assign ms_prod   = 34'(total_r) * 34'(pit_pkg::MS_RECIP);
  assign ms_left   = total_r - 17'(q_r) * pit_pkg::MS_PER_SEC;
  assign adj_sum   = {2'b00, adj_min_r} + {item_r.rotary[7], item_r.rotary};
  assign mv_diff   = item_r.timestamp_us - last_mv_r;
  assign mv_ok     = mv_diff >= {20'b0, cooldown_r};
  assign dsh_ext   = {1'b0, dsh_r};

  always_comb begin
    if (adj_sum < 9'sd1) adj_clamp = pit_pkg::MIN_LEN;
    else if (adj_sum > 9'sd99) adj_clamp = pit_pkg::MAX_LEN;
    else adj_clamp = adj_sum[6:0];
  end

  always_comb begin
    cooldown_nxt  = cfg_we ? cfg_wdata : cooldown_r;
    work_len_nxt  = work_len_r;
    break_len_nxt = break_len_r;
    in_work_nxt   = in_work_r;
    secs_nxt      = secs_r;
    running_nxt   = running_r;
    ms_acc_nxt    = ms_acc_r;
    pos_nxt       = pos_r;
    adj_nxt       = adj_r;
    adj_tgt_nxt   = adj_tgt_r;
    adj_min_nxt   = adj_min_r;
    last_mv_nxt   = last_mv_r;
    tick_cnt_nxt  = tick_cnt_r;
    dcnt_nxt      = dcnt_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    total_nxt     = total_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    quo_nxt       = quo_r;
    ang_ok_nxt    = ang_ok_r;
    back_nxt      = back_r;
    sw_nxt        = sw_r;
    mv_req        = 1'b0;
    mv_fwd        = 1'b0;

    if (cmd.latch) begin
      item_nxt  = in_item;
      total_nxt = {1'b0, in_item.elapsed_ms} + {7'b0, ms_acc_r};
      back_nxt  = 1'b0;
      sw_nxt    = 1'b0;
    end

    if (cmd.ms_mul) q_nxt = 7'(ms_prod >> pit_pkg::MS_RECIP_SHIFT);

    if (cmd.ms_rem) begin
      ms_acc_nxt   = ms_left[9:0];
      // drop whole seconds beyond the per-item limit
      tick_cnt_nxt = (q_r > 7'(MAX_SECONDS_PER_ITEM)) ? TW'(MAX_SECONDS_PER_ITEM) : TW'(q_r);
    end

    if (cmd.tick) begin
      tick_cnt_nxt = tick_cnt_r - 1'b1;
      if (running_r && secs_r != 13'd0) begin
        if (secs_r == 13'd1) begin
          in_work_nxt = ~in_work_r;
          secs_nxt    = min_to_sec(in_work_r ? break_len_r : work_len_r);
          sw_nxt      = 1'b1;
        end else begin
          secs_nxt = secs_r - 13'd1;
        end
      end
    end

    if (cmd.user) begin
      unique case (item_r.req_type)
        pit_pkg::REQ_USER: begin
          if (adj_r) begin
            if (item_r.short_press) begin
              if (!adj_tgt_r) work_len_nxt = adj_min_r;
              else break_len_nxt = adj_min_r;
              if (!running_r && (!adj_tgt_r == in_work_r)) secs_nxt = min_to_sec(adj_min_r);
              adj_nxt = 1'b0;
            end else if (item_r.rotary != 8'sd0) begin
              adj_min_nxt = adj_clamp;
            end
          end else if (item_r.short_press) begin
            if (pos_r == pit_pkg::BTN_BACK) begin
              back_nxt = 1'b1;
            end else begin
              if (pos_r == pit_pkg::BTN_START) begin
                if (running_r) begin
                  running_nxt = 1'b0;
                end else begin
                  if (secs_r == 13'd0) secs_nxt = cur_total;
                  running_nxt = 1'b1;
                end
              end else begin
                adj_nxt     = 1'b1;
                adj_tgt_nxt = (pos_r == pit_pkg::BTN_BREAK);
                adj_min_nxt = (pos_r == pit_pkg::BTN_WORK) ? work_len_r : break_len_r;
              end
              ms_acc_nxt = '0;
            end
          end else if (item_r.rotary != 8'sd0) begin
            mv_req = 1'b1;
            mv_fwd = !item_r.rotary[7];
          end else if (item_r.tilt == pit_pkg::TILT_FRONT || item_r.tilt == pit_pkg::TILT_BACK) begin
            mv_req = 1'b1;
            mv_fwd = (item_r.tilt == pit_pkg::TILT_FRONT);
          end
          if (mv_req && mv_ok) begin
            last_mv_nxt = item_r.timestamp_us;
            pos_nxt     = mv_fwd ? pos_r + 2'd1 : pos_r - 2'd1;
          end
        end
        pit_pkg::REQ_PAGE: begin
          pos_nxt     = pit_pkg::BTN_START;
          adj_nxt     = 1'b0;
          ms_acc_nxt  = '0;
          last_mv_nxt = '0;
        end
        default: ;
      endcase
    end

    if (cmd.ang_load) begin
      rem_nxt    = 22'(secs_r) * 22'(pit_pkg::ANGLE_FULL);
      dsh_nxt    = {cur_total, (pit_pkg::ANG_QW - 1)'(0)};
      quo_nxt    = '0;
      dcnt_nxt   = DCW'(pit_pkg::ANG_QW - 1);
      ang_ok_nxt = (cur_total != 13'd0) && (secs_r < cur_total);
    end

    // restoring divide, one quotient bit a cycle
    if (cmd.div_step) begin
      if (rem_r >= dsh_ext) begin
        rem_nxt = rem_r - dsh_ext;
        quo_nxt = {quo_r[pit_pkg::ANG_QW-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[pit_pkg::ANG_QW-2:0], 1'b0};
      end
      dsh_nxt  = dsh_r >> 1;
      dcnt_nxt = dcnt_r - 1'b1;
    end

    if (cmd.load_out) begin
      out_nxt.secs_remain    = secs_r;
      out_nxt.work_phase     = in_work_r;
      out_nxt.running        = running_r;
      out_nxt.work_min       = work_len_r;
      out_nxt.break_min      = break_len_r;
      out_nxt.adjusting      = adj_r;
      out_nxt.adjust_value   = adj_r ? adj_min_r : 7'd0;
      out_nxt.button_index   = pos_r;
      out_nxt.go_back        = back_r;
      out_nxt.phase_switched = sw_r;
      out_nxt.dial_angle     = ang_ok_r ? pit_pkg::ANGLE_FULL - quo_r : 9'd0;
    end
  end

  assign sts.tick_zero = (tick_cnt_r == '0);
  assign sts.div_last  = (dcnt_r == '0);
  assign out_item      = out_r;

endmodule

>>> hw/rtl/pomodoro_interval_timer.sv
// Work/break countdown timer with a four-entry action carousel.
// Input channel in_valid/in_ready/in_item carries time items (elapsed ms)
// and user items (tilt, rotary, short press, page open). Every accepted
// item yields exactly one result on out_valid/out_ready/out_item: the
// timer state, carousel position, pulses and the progress angle.
// cfg_we/cfg_wdata write the carousel cooldown in microseconds; write it
// only while no item is in flight.
// Time items tick through their whole seconds, at most MAX_SECONDS_PER_ITEM
// of them, one per cycle; user items skip this step. The progress angle then
// comes from a 9-bit restoring divider. One item is in work at a time: a new
// item is taken only once the result of the last one has been loaded into
// the output register.
// The result sits in an output register: the next item is accepted while
// it waits, and that item's result is held until the receiver takes the
// previous one.
// Synchronous reset loads the default phase lengths, work phase, stopped
// timer, carousel at entry 0 and a cooldown of 300000 us.
module pomodoro_interval_timer #(
  parameter int DEFAULT_WORK_MIN     = 25,
  parameter int DEFAULT_BREAK_MIN    = 5,
  parameter int MAX_SECONDS_PER_ITEM = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pit_pkg::pit_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pit_pkg::pit_out_t out_item,
  input  logic              cfg_we,
  input  logic [19:0]       cfg_wdata
);

  pit_pkg::cmd_t cmd;
  pit_pkg::sts_t sts;

  pit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_item.req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pit_dp #(
    .DEFAULT_WORK_MIN     (DEFAULT_WORK_MIN),
    .DEFAULT_BREAK_MIN    (DEFAULT_BREAK_MIN),
    .MAX_SECONDS_PER_ITEM (MAX_SECONDS_PER_ITEM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
